[src/vvp_pkg.sv]
// ----------------------------------------------------------------------------
// vvp_pkg
// Shared widths, register codes, reset values and types for the vertex
// view projection block.
// ----------------------------------------------------------------------------
package vvp_pkg;

    localparam int VTX_W     = 32;
    localparam int ADJ_W     = VTX_W + 1;
    localparam int COEF_W    = 21;
    localparam int ROT_W     = 40;
    localparam int FOCAL_W   = 16;
    localparam int PIX_W     = 16;
    localparam int CFG_W     = 63;
    localparam int IDX_W     = 3;
    localparam int FAR_SCALE = 1000;
    localparam int FAR_K_W   = FOCAL_W + 10;
    localparam int FAR_SHIFT = 17;
    localparam int BIG_BIT   = 32;

    typedef enum logic [IDX_W-1:0] {
        REG_COL_X   = 3'd0,
        REG_COL_Y   = 3'd1,
        REG_COL_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5,
        REG_FOCAL   = 3'd6
    } vvp_reg_t;

    localparam logic [CFG_W-1:0]          RST_COL_X   = 63'd262144;
    localparam logic [CFG_W-1:0]          RST_COL_Y   = 63'd549755813888;
    localparam logic [CFG_W-1:0]          RST_COL_Z   = 63'd1152921504606846976;
    localparam logic signed [VTX_W-1:0]   RST_SHIFT_X = 32'sd0;
    localparam logic signed [VTX_W-1:0]   RST_SHIFT_Y = 32'sd0;
    localparam logic signed [VTX_W-1:0]   RST_SHIFT_Z = 32'sd851968;
    localparam logic signed [FOCAL_W-1:0] RST_FOCAL   = 16'sd400;

    typedef struct packed {
        logic [CFG_W-1:0]          col_x;
        logic [CFG_W-1:0]          col_y;
        logic [CFG_W-1:0]          col_z;
        logic signed [VTX_W-1:0]   shift_x;
        logic signed [VTX_W-1:0]   shift_y;
        logic signed [VTX_W-1:0]   shift_z;
        logic signed [FOCAL_W-1:0] focal;
    } vvp_cfg_t;

    // rotated vertex with its classification
    typedef struct packed {
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ROT_W-1:0] rz;
        logic                    off;
        logic                    fe;
    } vvp_item_t;

    function automatic logic signed [PIX_W-1:0] sat16(input logic signed [63:0] v);
        logic signed [PIX_W-1:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[PIX_W-1:0];
        return r;
    endfunction

endpackage

[src/vvp_if.sv]
// ----------------------------------------------------------------------------
// vvp channel interfaces
// Vertex input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface vvp_vertex_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vvp_pkg::VTX_W-1:0]     vertex_x;
    logic signed [vvp_pkg::VTX_W-1:0]     vertex_y;
    logic signed [vvp_pkg::VTX_W-1:0]     vertex_z;
    logic                                 frame_end;
    modport source (output valid, vertex_x, vertex_y, vertex_z, frame_end, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, frame_end, output ready);
endinterface

interface vvp_pixel_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vvp_pkg::PIX_W-1:0]     screen_x;
    logic signed [vvp_pkg::PIX_W-1:0]     screen_y;
    logic                                 off_screen;
    logic                                 frame_end_out;
    modport source (output valid, screen_x, screen_y, off_screen, frame_end_out, input ready);
    modport sink   (input valid, screen_x, screen_y, off_screen, frame_end_out, output ready);
endinterface

interface vvp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vvp_pkg::IDX_W-1:0]     index;
    logic [vvp_pkg::CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/vvp_front.sv]
// ----------------------------------------------------------------------------
// vvp_front
// Offset, 3x3 rotation and on-screen classification, five stages.
// ----------------------------------------------------------------------------
module vvp_front #(
    parameter int SCREEN_W       = 700,
    parameter int SCREEN_H       = 700,
    parameter int COEF_FRAC_BITS = 18
) (
    input  logic              clk,
    input  logic              rst_n,
    vvp_vertex_if.sink        vertex,
    input  vvp_pkg::vvp_cfg_t cfg,
    input  logic              en,
    output logic              push,
    output vvp_pkg::vvp_item_t item
);
    import vvp_pkg::*;

    localparam int PROD_W = ADJ_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int HMAX   = (SCREEN_W > SCREEN_H) ? SCREEN_W / 2 : SCREEN_H / 2;
    localparam int HZ_W   = ROT_W + $clog2(HMAX + 1) + 1;
    localparam logic signed [HZ_W-1:0]  HW_C = HZ_W'(SCREEN_W / 2);
    localparam logic signed [HZ_W-1:0]  HH_C = HZ_W'(SCREEN_H / 2);
    localparam logic signed [SUM_W-1:0] RND  = SUM_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ZERO = '0;
    localparam logic signed [SUM_W-1:0] RMAX = SUM_W'((64'sd1 <<< (ROT_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] RMIN = -SUM_W'(64'sd1 <<< (ROT_W - 1));

    logic [4:0]               vld_reg;
    logic [4:0]               fe_reg;
    logic signed [ADJ_W-1:0]  adj_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [ROT_W-1:0]  rot_reg [3];
    logic signed [ROT_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic [ROT_W-1:0]         ax_reg, ay_reg;
    logic signed [HZ_W-1:0]   hwz_reg, hhz_reg;
    logic [CFG_W-1:0]         col [3];

    assign col[0] = cfg.col_x;
    assign col[1] = cfg.col_y;
    assign col[2] = cfg.col_z;

    assign vertex.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], vertex.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_reg     <= {fe_reg[3:0], vertex.frame_end};
            adj_reg[0] <= ADJ_W'(vertex.vertex_x) + ADJ_W'(cfg.shift_x);
            adj_reg[1] <= ADJ_W'(vertex.vertex_y) + ADJ_W'(cfg.shift_y);
            adj_reg[2] <= ADJ_W'(vertex.vertex_z) + ADJ_W'(cfg.shift_z);
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[r][k] <= PROD_W'(adj_reg[k])
                                      * PROD_W'($signed(col[r][k*COEF_W +: COEF_W]));
                end
                sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                              + SUM_W'(prod_reg[r][2]);
            end
            // truncate toward zero, then clamp to 40 bits
            for (int r = 0; r < 3; r++)
            begin
                if (((sum_reg[r] + (sum_reg[r] < 0 ? RND : ZERO)) >>> COEF_FRAC_BITS) > RMAX)
                    rot_reg[r] <= RMAX[ROT_W-1:0];
                else if (((sum_reg[r] + (sum_reg[r] < 0 ? RND : ZERO)) >>> COEF_FRAC_BITS)
                         < RMIN)
                    rot_reg[r] <= RMIN[ROT_W-1:0];
                else
                    rot_reg[r] <= ROT_W'((sum_reg[r] + (sum_reg[r] < 0 ? RND : ZERO))
                                         >>> COEF_FRAC_BITS);
            end
            rx_reg  <= rot_reg[0];
            ry_reg  <= rot_reg[1];
            rz_reg  <= rot_reg[2];
            ax_reg  <= rot_reg[0] < 0 ? ROT_W'(-rot_reg[0]) : ROT_W'(rot_reg[0]);
            ay_reg  <= rot_reg[1] < 0 ? ROT_W'(-rot_reg[1]) : ROT_W'(rot_reg[1]);
            hwz_reg <= HZ_W'(rot_reg[2]) * HW_C;
            hhz_reg <= HZ_W'(rot_reg[2]) * HH_C;
        end
    end

    assign push     = en && vld_reg[4];
    assign item.rx  = rx_reg;
    assign item.ry  = ry_reg;
    assign item.rz  = rz_reg;
    assign item.fe  = fe_reg[4];
    assign item.off = (rz_reg <= 0)
                      || ($signed(HZ_W'({1'b0, ax_reg})) > hwz_reg)
                      || ($signed(HZ_W'({1'b0, ay_reg})) > hhz_reg);

endmodule

[src/vvp_queue.sv]
// ----------------------------------------------------------------------------
// vvp_queue
// Short queue of classified vertices between front and back.
// ----------------------------------------------------------------------------
module vvp_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vvp_pkg::vvp_item_t push_item,
    output logic               space,
    input  logic               pop,
    output logic               head_valid,
    output vvp_pkg::vvp_item_t head_item
);
    import vvp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vvp_item_t     mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign space      = cnt_reg < CW'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_item  = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

[src/vvp_back.sv]
// ----------------------------------------------------------------------------
// vvp_back
// Focal scaling, pipelined restoring divide by depth, centering, clamping.
// ----------------------------------------------------------------------------
module vvp_back #(
    parameter int SCREEN_W = 700,
    parameter int SCREEN_H = 700
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vvp_pkg::vvp_cfg_t  cfg,
    input  logic               head_valid,
    input  vvp_pkg::vvp_item_t head_item,
    output logic               pop,
    vvp_pixel_if.source        pixel
);
    import vvp_pkg::*;

    localparam int SMAX  = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int HMAX  = SMAX / 2;
    localparam int QW    = $clog2(HMAX + 1) + FOCAL_W;
    localparam int PF_W  = ROT_W + FOCAL_W;
    localparam int WZ_W  = ROT_W + $clog2(SMAX + 1) + 1;
    localparam int N_W   = ((PF_W + 1 > WZ_W) ? PF_W + 1 : WZ_W) + 1;
    localparam int DW    = ROT_W + 1;
    localparam int CMP_W = ((N_W > DW + QW) ? N_W : DW + QW) + 1;
    localparam int P_W   = BIG_BIT + 1 + FAR_K_W;
    localparam int T_W   = P_W + 2;
    localparam logic signed [WZ_W-1:0]    W_C  = WZ_W'(SCREEN_W);
    localparam logic signed [WZ_W-1:0]    H_C  = WZ_W'(SCREEN_H);
    localparam logic signed [T_W-1:0]     WF_C = T_W'(SCREEN_W) <<< 16;
    localparam logic signed [T_W-1:0]     HF_C = T_W'(SCREEN_H) <<< 16;
    localparam logic signed [T_W-1:0]     FRND = T_W'((64'sd1 <<< FAR_SHIFT) - 64'sd1);
    localparam logic signed [T_W-1:0]     FZERO = '0;
    localparam logic signed [ROT_W-1:0]   BIGP = ROT_W'(64'sd1 <<< BIG_BIT);
    localparam logic signed [FAR_K_W-1:0] K_C  = FAR_K_W'(FAR_SCALE);

    typedef struct packed {
        logic                    off;
        logic                    fe;
        logic [DW-1:0]           d;
        logic signed [PIX_W-1:0] farx;
        logic signed [PIX_W-1:0] fary;
        logic                    negx;
        logic                    negy;
    } side_t;

    logic en;
    logic signed [FAR_K_W-1:0] k_reg;

    // stage 1: products
    logic [1:0]                v_reg;
    logic [1:0]                off_reg, fe_reg;
    logic signed [PF_W-1:0]    pxf_reg, pyf_reg;
    logic signed [WZ_W-1:0]    wz_reg, hz_reg;
    logic signed [P_W-1:0]     px_reg, py_reg;
    logic [1:0]                bigx_reg, bigy_reg, sgx_reg, sgy_reg;
    logic [DW-1:0]             d1_reg, d2_reg;
    // stage 2: numerators
    logic signed [N_W-1:0]     nx_reg, ny_reg;
    logic signed [T_W-1:0]     tx_reg, ty_reg;
    // divider pipeline
    logic                      dv_reg [QW+1];
    side_t                     side_reg [QW+1];
    logic [N_W-1:0]            remx_reg [QW+1];
    logic [N_W-1:0]            remy_reg [QW+1];
    logic [QW-1:0]             qx_reg [QW+1];
    logic [QW-1:0]             qy_reg [QW+1];
    // output register
    logic                      ov_reg;
    logic signed [PIX_W-1:0]   sx_reg, sy_reg;
    logic                      os_reg, oe_reg;

    logic signed [QW:0] qsx, qsy;

    assign en  = !ov_reg || pixel.ready;
    assign pop = en && head_valid;

    always_ff @(posedge clk)
    begin
        k_reg <= FAR_K_W'(cfg.focal) * K_C;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
            for (int j = 0; j <= QW; j++)
                dv_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[0], head_valid};
            dv_reg[0] <= v_reg[1];
            for (int j = 1; j <= QW; j++)
                dv_reg[j] <= dv_reg[j-1];
            ov_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxf_reg  <= PF_W'(head_item.rx) * PF_W'(cfg.focal);
            pyf_reg  <= PF_W'(head_item.ry) * PF_W'(cfg.focal);
            wz_reg   <= WZ_W'(head_item.rz) * W_C;
            hz_reg   <= WZ_W'(head_item.rz) * H_C;
            px_reg   <= P_W'($signed(head_item.rx[BIG_BIT:0])) * P_W'(k_reg);
            py_reg   <= P_W'($signed(head_item.ry[BIG_BIT:0])) * P_W'(k_reg);
            bigx_reg <= {bigx_reg[0], (cfg.focal != 0)
                         && (head_item.rx >= BIGP || head_item.rx <= -BIGP)};
            bigy_reg <= {bigy_reg[0], (cfg.focal != 0)
                         && (head_item.ry >= BIGP || head_item.ry <= -BIGP)};
            // sign of the saturated far result; y is negated
            sgx_reg  <= {sgx_reg[0], (head_item.rx < 0) != (cfg.focal < 0)};
            sgy_reg  <= {sgy_reg[0], (head_item.ry < 0) == (cfg.focal < 0)};
            off_reg  <= {off_reg[0], head_item.off};
            fe_reg   <= {fe_reg[0], head_item.fe};
            d1_reg   <= {head_item.rz[ROT_W-1:0], 1'b0};
            d2_reg   <= d1_reg;

            nx_reg <= (N_W'(pxf_reg) <<< 1) + N_W'(wz_reg);
            ny_reg <= N_W'(hz_reg) - (N_W'(pyf_reg) <<< 1);
            tx_reg <= (T_W'(px_reg) <<< 1) + WF_C;
            ty_reg <= HF_C - (T_W'(py_reg) <<< 1);

            side_reg[0].off  <= off_reg[1];
            side_reg[0].fe   <= fe_reg[1];
            side_reg[0].d    <= d2_reg;
            side_reg[0].negx <= nx_reg < 0;
            side_reg[0].negy <= ny_reg < 0;
            if (bigx_reg[1])
                side_reg[0].farx <= sgx_reg[1] ? 16'sh8000 : 16'sh7fff;
            else
                side_reg[0].farx <= sat16(64'((tx_reg + (tx_reg < 0 ? FRND : FZERO))
                                              >>> FAR_SHIFT));
            if (bigy_reg[1])
                side_reg[0].fary <= sgy_reg[1] ? 16'sh8000 : 16'sh7fff;
            else
                side_reg[0].fary <= sat16(64'((ty_reg + (ty_reg < 0 ? FRND : FZERO))
                                              >>> FAR_SHIFT));
            remx_reg[0] <= nx_reg < 0 ? N_W'(-nx_reg) : N_W'(nx_reg);
            remy_reg[0] <= ny_reg < 0 ? N_W'(-ny_reg) : N_W'(ny_reg);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;

            // one quotient bit per stage, most significant first
            for (int j = 1; j <= QW; j++)
            begin
                side_reg[j] <= side_reg[j-1];
                if (CMP_W'(remx_reg[j-1]) >= (CMP_W'(side_reg[j-1].d) << (QW - j)))
                begin
                    remx_reg[j] <= N_W'(CMP_W'(remx_reg[j-1])
                                        - (CMP_W'(side_reg[j-1].d) << (QW - j)));
                    qx_reg[j]   <= qx_reg[j-1] | (QW'(1) << (QW - j));
                end
                else
                begin
                    remx_reg[j] <= remx_reg[j-1];
                    qx_reg[j]   <= qx_reg[j-1];
                end
                if (CMP_W'(remy_reg[j-1]) >= (CMP_W'(side_reg[j-1].d) << (QW - j)))
                begin
                    remy_reg[j] <= N_W'(CMP_W'(remy_reg[j-1])
                                        - (CMP_W'(side_reg[j-1].d) << (QW - j)));
                    qy_reg[j]   <= qy_reg[j-1] | (QW'(1) << (QW - j));
                end
                else
                begin
                    remy_reg[j] <= remy_reg[j-1];
                    qy_reg[j]   <= qy_reg[j-1];
                end
            end

            os_reg <= side_reg[QW].off;
            oe_reg <= side_reg[QW].fe;
            sx_reg <= side_reg[QW].off ? side_reg[QW].farx : sat16(64'(qsx));
            sy_reg <= side_reg[QW].off ? side_reg[QW].fary : sat16(64'(qsy));
        end
    end

    assign qsx = side_reg[QW].negx ? -$signed({1'b0, qx_reg[QW]}) : $signed({1'b0, qx_reg[QW]});
    assign qsy = side_reg[QW].negy ? -$signed({1'b0, qy_reg[QW]}) : $signed({1'b0, qy_reg[QW]});

    assign pixel.valid         = ov_reg;
    assign pixel.screen_x      = sx_reg;
    assign pixel.screen_y      = sy_reg;
    assign pixel.off_screen    = os_reg;
    assign pixel.frame_end_out = oe_reg;

endmodule

[src/vertex_view_projection.sv]
// ----------------------------------------------------------------------------
// vertex_view_projection
// Perspective projection of one Q16.16 vertex to a clamped screen pixel.
//
//   channel  dir  handshake      payload
//   vertex   in   valid/ready    vertex_x, vertex_y, vertex_z, frame_end
//   pixel    out  valid/ready    screen_x, screen_y, off_screen, frame_end_out
//   cfg      in   valid/ready    index, data (ready always high)
//
// one vertex per cycle sustained while the pixel output is ready; the back
// pipe holds a restoring divider that takes one quotient bit per stage for a
// QW-bit quotient, QW = clog2(max(W,H)/2 + 1) + 16 (25 at 700x700).
// reset clears all valid bits and loads the register defaults.
// a stalled pixel output freezes the back pipe; the four-entry queue keeps
// the front running until it fills.
// ----------------------------------------------------------------------------
module vertex_view_projection #(
    parameter int SCREEN_W       = 700,
    parameter int SCREEN_H       = 700,
    parameter int COEF_FRAC_BITS = 18
) (
    input  logic         clk,
    input  logic         rst_n,
    vvp_vertex_if.sink   vertex,
    vvp_pixel_if.source  pixel,
    vvp_cfg_if.sink      cfg
);
    import vvp_pkg::*;

    vvp_cfg_t  cfg_reg;
    vvp_item_t push_item, head_item;
    logic      push, space, pop, head_valid;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col_x   <= RST_COL_X;
            cfg_reg.col_y   <= RST_COL_Y;
            cfg_reg.col_z   <= RST_COL_Z;
            cfg_reg.shift_x <= RST_SHIFT_X;
            cfg_reg.shift_y <= RST_SHIFT_Y;
            cfg_reg.shift_z <= RST_SHIFT_Z;
            cfg_reg.focal   <= RST_FOCAL;
        end
        else if (cfg.valid)
        begin
            case (vvp_reg_t'(cfg.index))
                REG_COL_X:   cfg_reg.col_x   <= cfg.data;
                REG_COL_Y:   cfg_reg.col_y   <= cfg.data;
                REG_COL_Z:   cfg_reg.col_z   <= cfg.data;
                REG_SHIFT_X: cfg_reg.shift_x <= cfg.data[VTX_W-1:0];
                REG_SHIFT_Y: cfg_reg.shift_y <= cfg.data[VTX_W-1:0];
                REG_SHIFT_Z: cfg_reg.shift_z <= cfg.data[VTX_W-1:0];
                REG_FOCAL:   cfg_reg.focal   <= cfg.data[FOCAL_W-1:0];
                default:     ;
            endcase
        end
    end

    vvp_front #(
        .SCREEN_W       (SCREEN_W),
        .SCREEN_H       (SCREEN_H),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex),
        .cfg    (cfg_reg),
        .en     (space),
        .push   (push),
        .item   (push_item)
    );

    vvp_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .space      (space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    vvp_back #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule
